// ----- src/pts_pkg.sv -----
// shared constants and types for the priority task scheduler
`timescale 1ns / 1ps
package pts_pkg;
   localparam int NUM_TASKS   = 8;
   localparam int TASK_W      = $clog2(NUM_TASKS);
   localparam int CNT_W       = $clog2(NUM_TASKS + 1);
   localparam int PRIO_LEVELS = 32;
   localparam int PRIO_W      = $clog2(PRIO_LEVELS);
   localparam int DELAY_W     = 16;
   localparam int LOCK_W      = 8;
   localparam int OP_W        = 3;
   localparam int PRIO_TAB_W  = 40;
   localparam int MASK_W      = 8;
   localparam int SLICE_W     = 8;
   localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;

   typedef enum logic [OP_W-1:0] {
      OP_START  = 3'd0,
      OP_TICK   = 3'd1,
      OP_DELAY  = 3'd2,
      OP_LOCK   = 3'd3,
      OP_UNLOCK = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      REG_PRIO   = 2'd0,
      REG_ENABLE = 2'd1,
      REG_SLICE  = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [PRIO_TAB_W-1:0] prio_table;
      logic [MASK_W-1:0]     enable_mask;
      logic [SLICE_W-1:0]    slice_length;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [TASK_W-1:0] current_task;
      logic              task_switched;
      logic              none_ready;
      logic [LOCK_W-1:0] lock_count;
      logic [MASK_W-1:0] ready_mask;
   } rsp_type;
endpackage

// ----- src/pts_engine.sv -----
// scheduling sequencer with the per-priority queue memory
`timescale 1ns / 1ps
module pts_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  pts_pkg::cfg_type            cfg,
   input  logic                        start,
   input  logic [pts_pkg::OP_W-1:0]    operation,
   input  logic [pts_pkg::DELAY_W-1:0] delay_ticks,
   output logic                        busy,
   output pts_pkg::rsp_type            rsp
);
   import pts_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_ST_LOOP, S_TK_LOOP, S_TK_SLICE, S_TK_PB,
      S_PF_RD, S_PF_EX, S_PB_RD, S_PB_EX, S_RM_RD, S_RM_EX, S_RM_WALK,
      S_RS, S_RS_RD, S_RS_EX, S_DONE
   } state_type;

   localparam int QW = 2 * TASK_W;

   logic [QW-1:0]        qmem [PRIO_LEVELS];
   logic [QW-1:0]        rdata_ff;
   logic                 wr_en_ff;
   logic [QW-1:0]        wr_data_ff;

   state_type            state_ff, ret_ff;
   logic [PRIO_W-1:0]    addr_ff;
   logic [TASK_W-1:0]    tk_ff;
   logic [TASK_W-1:0]    cur_ff;
   logic [TASK_W-1:0]    hd_ff, tl_ff;
   logic [TASK_W-1:0]    step_ff;
   logic [CNT_W-1:0]     idx_ff, kept_ff, dcount_ff;
   logic [TASK_W-1:0]    ready_next_ff [NUM_TASKS];
   logic [DELAY_W-1:0]   dcnt_ff       [NUM_TASKS];
   logic [TASK_W-1:0]    dorder_ff     [NUM_TASKS];
   logic [SLICE_W-1:0]   slice_ff      [NUM_TASKS];
   logic [NUM_TASKS-1:0] is_ready_ff;
   logic [PRIO_LEVELS-1:0] bitmap_ff;
   logic [LOCK_W-1:0]    lock_ff;
   logic [TASK_W-1:0]    running_ff, before_ff;

   logic [TASK_W-1:0]    q_head, q_tail, ord_t, run;
   logic [DELAY_W-1:0]   dec_cnt;
   logic [PRIO_W-1:0]    first_prio;

   function automatic logic [PRIO_W-1:0] prio_of(input logic [PRIO_TAB_W-1:0] tab,
                                                input logic [TASK_W-1:0] t);
      int                  idx;
      logic [PRIO_W-1:0]   p;
      idx = 5 * int'(t);
      p = PRIO_W'(tab >> idx);
      if ({1'b0, p} >= (PRIO_W+1)'(PRIO_LEVELS))
         p = PRIO_W'(PRIO_LEVELS - 1);
      return p;
   endfunction

   always_comb begin
      first_prio = '0;
      for (int p = PRIO_LEVELS - 1; p >= 0; p--) begin
         if (bitmap_ff[p])
            first_prio = PRIO_W'(p);
      end
   end

   assign q_head  = rdata_ff[QW-1:TASK_W];
   assign q_tail  = rdata_ff[TASK_W-1:0];
   assign ord_t   = dorder_ff[idx_ff[TASK_W-1:0]];
   assign dec_cnt = dcnt_ff[ord_t] - DELAY_W'(1);
   assign run     = running_ff;

   // queue memory, registered read
   always_ff @(posedge clock) begin
      rdata_ff <= qmem[addr_ff];
      if (wr_en_ff)
         qmem[addr_ff] <= wr_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ret_ff      <= S_IDLE;
         wr_en_ff    <= 1'b0;
         bitmap_ff   <= '0;
         is_ready_ff <= '0;
         dcount_ff   <= '0;
         lock_ff     <= '0;
         running_ff  <= '0;
         before_ff   <= '0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            dcnt_ff[i]  <= '0;
            slice_ff[i] <= '0;
         end
      end else begin
         wr_en_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  before_ff <= running_ff;
                  case (operation)
                     OP_START: begin
                        bitmap_ff   <= '0;
                        is_ready_ff <= '0;
                        dcount_ff   <= '0;
                        lock_ff     <= '0;
                        for (int i = 0; i < NUM_TASKS; i++) begin
                           dcnt_ff[i]  <= '0;
                           slice_ff[i] <= cfg.slice_length;
                        end
                        tk_ff    <= '0;
                        idx_ff   <= '0;
                        state_ff <= S_ST_LOOP;
                     end
                     OP_TICK: begin
                        idx_ff   <= '0;
                        kept_ff  <= '0;
                        state_ff <= S_TK_LOOP;
                     end
                     OP_DELAY: begin
                        if (is_ready_ff[run] && dcount_ff < CNT_W'(NUM_TASKS)) begin
                           dcnt_ff[run] <= delay_ticks;
                           dorder_ff[dcount_ff[TASK_W-1:0]] <= run;
                           dcount_ff <= dcount_ff + CNT_W'(1);
                           tk_ff    <= run;
                           addr_ff  <= prio_of(cfg.prio_table, run);
                           ret_ff   <= S_RS;
                           state_ff <= S_RM_RD;
                        end else begin
                           state_ff <= S_RS;
                        end
                     end
                     OP_LOCK: begin
                        if (lock_ff != LOCK_MAX)
                           lock_ff <= lock_ff + LOCK_W'(1);
                        state_ff <= S_DONE;
                     end
                     OP_UNLOCK: begin
                        if (lock_ff != '0) begin
                           lock_ff  <= lock_ff - LOCK_W'(1);
                           state_ff <= (lock_ff == LOCK_W'(1)) ? S_RS : S_DONE;
                        end else begin
                           state_ff <= S_DONE;
                        end
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_ST_LOOP: begin
               // idx_ff counts the tasks walked so far
               if (idx_ff == CNT_W'(NUM_TASKS)) begin
                  state_ff <= S_RS;
               end else begin
                  idx_ff <= idx_ff + CNT_W'(1);
                  if (cfg.enable_mask[idx_ff[TASK_W-1:0]]) begin
                     tk_ff    <= idx_ff[TASK_W-1:0];
                     addr_ff  <= prio_of(cfg.prio_table, idx_ff[TASK_W-1:0]);
                     ret_ff   <= S_ST_LOOP;
                     state_ff <= S_PF_RD;
                  end
               end
            end
            S_TK_LOOP: begin
               if (idx_ff < dcount_ff) begin
                  dcnt_ff[ord_t] <= dec_cnt;
                  idx_ff <= idx_ff + CNT_W'(1);
                  if (dec_cnt == '0) begin
                     tk_ff    <= ord_t;
                     addr_ff  <= prio_of(cfg.prio_table, ord_t);
                     ret_ff   <= S_TK_LOOP;
                     state_ff <= S_PF_RD;
                  end else begin
                     dorder_ff[kept_ff[TASK_W-1:0]] <= ord_t;
                     kept_ff <= kept_ff + CNT_W'(1);
                  end
               end else begin
                  dcount_ff <= kept_ff;
                  state_ff  <= S_TK_SLICE;
               end
            end
            S_TK_SLICE: begin
               if (slice_ff[run] <= SLICE_W'(1)) begin
                  slice_ff[run] <= cfg.slice_length;
                  if (is_ready_ff[run]) begin
                     tk_ff    <= run;
                     addr_ff  <= prio_of(cfg.prio_table, run);
                     ret_ff   <= S_TK_PB;
                     state_ff <= S_RM_RD;
                  end else begin
                     state_ff <= S_RS;
                  end
               end else begin
                  slice_ff[run] <= slice_ff[run] - SLICE_W'(1);
                  state_ff <= S_RS;
               end
            end
            S_TK_PB: begin
               tk_ff    <= run;
               addr_ff  <= prio_of(cfg.prio_table, run);
               ret_ff   <= S_RS;
               state_ff <= S_PB_RD;
            end
            S_PF_RD: state_ff <= S_PF_EX;
            S_PF_EX: begin
               if (bitmap_ff[addr_ff]) begin
                  ready_next_ff[tk_ff] <= q_head;
                  wr_data_ff <= {tk_ff, q_tail};
               end else begin
                  wr_data_ff <= {tk_ff, tk_ff};
               end
               bitmap_ff[addr_ff] <= 1'b1;
               is_ready_ff[tk_ff] <= 1'b1;
               wr_en_ff <= 1'b1;
               state_ff <= ret_ff;
            end
            S_PB_RD: state_ff <= S_PB_EX;
            S_PB_EX: begin
               if (bitmap_ff[addr_ff]) begin
                  ready_next_ff[q_tail] <= tk_ff;
                  wr_data_ff <= {q_head, tk_ff};
               end else begin
                  wr_data_ff <= {tk_ff, tk_ff};
               end
               bitmap_ff[addr_ff] <= 1'b1;
               is_ready_ff[tk_ff] <= 1'b1;
               wr_en_ff <= 1'b1;
               state_ff <= ret_ff;
            end
            S_RM_RD: state_ff <= S_RM_EX;
            S_RM_EX: begin
               if (!is_ready_ff[tk_ff] || !bitmap_ff[addr_ff]) begin
                  state_ff <= ret_ff;
               end else begin
                  is_ready_ff[tk_ff] <= 1'b0;
                  if (q_head == tk_ff) begin
                     if (q_tail == tk_ff) begin
                        bitmap_ff[addr_ff] <= 1'b0;
                     end else begin
                        wr_data_ff <= {ready_next_ff[tk_ff], q_tail};
                        wr_en_ff   <= 1'b1;
                     end
                     state_ff <= ret_ff;
                  end else begin
                     hd_ff    <= q_head;
                     tl_ff    <= q_tail;
                     cur_ff   <= q_head;
                     step_ff  <= '0;
                     state_ff <= S_RM_WALK;
                  end
               end
            end
            S_RM_WALK: begin
               if (ready_next_ff[cur_ff] == tk_ff) begin
                  ready_next_ff[cur_ff] <= ready_next_ff[tk_ff];
                  if (tl_ff == tk_ff) begin
                     wr_data_ff <= {hd_ff, cur_ff};
                     wr_en_ff   <= 1'b1;
                  end
                  state_ff <= ret_ff;
               end else if (cur_ff == tl_ff || step_ff == TASK_W'(NUM_TASKS - 1)) begin
                  state_ff <= ret_ff;
               end else begin
                  cur_ff  <= ready_next_ff[cur_ff];
                  step_ff <= step_ff + TASK_W'(1);
               end
            end
            S_RS: begin
               if (lock_ff != '0 || bitmap_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  addr_ff  <= first_prio;
                  state_ff <= S_RS_RD;
               end
            end
            S_RS_RD: state_ff <= S_RS_EX;
            S_RS_EX: begin
               running_ff <= q_head;
               state_ff   <= S_DONE;
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp.valid         = (state_ff == S_DONE);
   assign rsp.current_task  = running_ff;
   assign rsp.task_switched = (running_ff != before_ff);
   assign rsp.none_ready    = (bitmap_ff == '0);
   assign rsp.lock_count    = lock_ff;
   assign rsp.ready_mask    = MASK_W'(is_ready_ff);

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (state_ff == S_IDLE))
      else $error("result beat not followed by idle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not make the engine busy");
   a_empty_none_ready: assert property (@(posedge clock) disable iff (reset)
      (bitmap_ff == '0) |-> (is_ready_ff == '0))
      else $error("ready task with empty priority bitmap");
   a_dcount_range: assert property (@(posedge clock) disable iff (reset)
      dcount_ff <= CNT_W'(NUM_TASKS))
      else $error("delay list overflow");
endmodule

// ----- src/priority_task_scheduler_core.sv -----
// top level: register port, command channel and result strobe
`timescale 1ns / 1ps
// lock, unlock and unknown commands: result strobe in the cycle after acceptance,
// or after S_RS (then S_RS_RD and S_RS_EX if a task is ready) when an unlock reaches zero
// start: pushes each enabled task onto its priority queue (S_PF_RD, S_PF_EX), then reschedules
// tick and delay: delay list walk, queue unlink walk and queue memory reads
// one command at a time; busy stays high until the result beat
// synchronous reset empties the queues and delay list and clears lock and running task
module priority_task_scheduler_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pts_pkg::OP_W-1:0]       req_operation,
   input  logic [pts_pkg::DELAY_W-1:0]    req_delay_ticks,
   output logic                           rsp_valid,
   output logic [pts_pkg::TASK_W-1:0]     rsp_current_task,
   output logic                           rsp_task_switched,
   output logic                           rsp_none_ready,
   output logic [pts_pkg::LOCK_W-1:0]     rsp_lock_count,
   output logic [pts_pkg::MASK_W-1:0]     rsp_ready_mask,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [4:0]                     paddr,
   input  logic [63:0]                    pwdata,
   output logic [63:0]                    prdata,
   output logic                           pready
);
   import pts_pkg::*;

   cfg_type     cfg_ff;
   rsp_type     rsp;
   reg_idx_type reg_sel;
   logic        wr_beat;

   assign pready  = 1'b1;
   assign reg_sel = reg_idx_type'(paddr[4:3]);
   assign wr_beat = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prio_table   <= '0;
         cfg_ff.enable_mask  <= '0;
         cfg_ff.slice_length <= SLICE_W'(10);
      end else if (wr_beat) begin
         case (reg_sel)
            REG_PRIO:   cfg_ff.prio_table   <= pwdata[PRIO_TAB_W-1:0];
            REG_ENABLE: cfg_ff.enable_mask  <= pwdata[MASK_W-1:0];
            REG_SLICE:  cfg_ff.slice_length <= pwdata[SLICE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PRIO:   prdata = 64'(cfg_ff.prio_table);
         REG_ENABLE: prdata = 64'(cfg_ff.enable_mask);
         REG_SLICE:  prdata = 64'(cfg_ff.slice_length);
         default:    prdata = '0;
      endcase
   end

   pts_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start       (start),
      .operation   (req_operation),
      .delay_ticks (req_delay_ticks),
      .busy        (busy),
      .rsp         (rsp)
   );

   assign rsp_valid         = rsp.valid;
   assign rsp_current_task  = rsp.current_task;
   assign rsp_task_switched = rsp.task_switched;
   assign rsp_none_ready    = rsp.none_ready;
   assign rsp_lock_count    = rsp.lock_count;
   assign rsp_ready_mask    = rsp.ready_mask;
endmodule
